FILE: hw/rtl/chrr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and state encodings for the consistent-hash ring router.
// Used by chrr_hash, chrr_search and the top level; depends on nothing.
package chrr_pkg;

   localparam int RING_DEPTH     = 256;
   localparam int NODE_COUNT_MAX = 64;
   localparam int RING_IDX_W     = $clog2(RING_DEPTH);
   localparam int RING_CNT_W     = $clog2(RING_DEPTH + 1);
   localparam int NODE_W         = 6;
   localparam int NODE_STORE_W   = (NODE_COUNT_MAX > 1) ? $clog2(NODE_COUNT_MAX) : 1;
   localparam int CFG_SIZE_W     = 9;
   localparam int HASH_W         = 32;

   localparam logic [HASH_W-1:0] SEED_VALUE = 32'h0000_0001;
   localparam logic [HASH_W-1:0] MM_C1      = 32'hcc9e_2d51;
   localparam logic [HASH_W-1:0] MM_C2      = 32'h1b87_3593;
   localparam logic [HASH_W-1:0] MM_FMIX1   = 32'h85eb_ca6b;
   localparam logic [HASH_W-1:0] MM_FMIX2   = 32'hc2b2_ae35;
   localparam logic [HASH_W-1:0] MM_ROUND_N = 32'he654_6b64;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_KEY  = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [7:0]  entry_index;
      logic [31:0] entry_hash;
      logic [5:0]  entry_node;
      logic [7:0]  key_byte;
      logic        byte_present;
      logic        key_last;
   } req_item_type;

   typedef struct packed {
      logic [5:0] node_index;
      logic       empty_error;
   } rsp_item_type;

   typedef struct packed {
      logic [HASH_W-1:0] hash;
      logic [NODE_W-1:0] node;
   } ring_entry_type;

   localparam int ENTRY_W = $bits(ring_entry_type);

   typedef struct packed {
      logic busy;
      logic done;
   } hash_stat_type;

   typedef struct packed {
      logic              busy;
      logic              valid;
      logic [NODE_W-1:0] node;
      logic              empty;
   } srch_res_type;

   typedef enum logic [3:0] {
      H_IDLE,
      H_MIX1,
      H_MIX2,
      H_ROUND,
      H_FIN,
      H_FXOR,
      H_FM1,
      H_FM2,
      H_FM3
   } hash_state_type;

   typedef enum logic {
      SR_IDLE,
      SR_SCAN
   } srch_state_type;

endpackage

FILE: hw/rtl/chrr_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the ring entries of the router.
module chrr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/chrr_hash.sv
`timescale 1ns / 1ps
// MurmurHash3 x86_32 key hasher built around one shared 32-bit multiplier.
// Depends on chrr_pkg for constants, item types and the sequencer states.
module chrr_hash
   import chrr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              key_fire,
   input  req_item_type      key_item,
   input  logic              go_ok,
   output hash_stat_type     stat,
   output logic [HASH_W-1:0] lookup_hash
);

   hash_state_type    state_ff, state_in;
   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [HASH_W-1:0] len_ff, len_in;
   logic [23:0]       part_ff, part_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic [HASH_W-1:0] acc_ff, acc_in;
   logic              last_ff, last_in;
   logic              tail_ff, tail_in;

   logic [HASH_W-1:0] mul_a, mul_b, prod;
   logic [HASH_W-1:0] round_x, round_r;

   assign prod    = mul_a * mul_b;
   assign round_x = hash_ff ^ acc_ff;
   assign round_r = {round_x[18:0], round_x[31:19]};
   assign lookup_hash = acc_ff ^ (acc_ff >> 16);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         hash_ff  <= SEED_VALUE;
         len_ff   <= '0;
         part_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         hash_ff  <= hash_in;
         len_ff   <= len_in;
         part_ff  <= part_in;
         cnt_ff   <= cnt_in;
      end
      acc_ff  <= acc_in;
      last_ff <= last_in;
      tail_ff <= tail_in;
   end

   always_comb begin
      state_in  = state_ff;
      hash_in   = hash_ff;
      len_in    = len_ff;
      part_in   = part_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      last_in   = last_ff;
      tail_in   = tail_ff;
      mul_a     = acc_ff;
      mul_b     = '0;
      stat.busy = (state_ff != H_IDLE);
      stat.done = 1'b0;
      unique case (state_ff)
         H_IDLE: begin
            if (key_fire) begin
               len_in = len_ff + HASH_W'(key_item.byte_present);
               if (key_item.byte_present && (cnt_ff == 2'd3)) begin
                  acc_in   = {key_item.key_byte, part_ff};
                  part_in  = '0;
                  cnt_in   = '0;
                  tail_in  = 1'b0;
                  last_in  = key_item.key_last;
                  state_in = H_MIX1;
               end else begin
                  if (key_item.byte_present) begin
                     case (cnt_ff)
                        2'd0:    part_in = {part_ff[23:8], key_item.key_byte};
                        2'd1:    part_in = {part_ff[23:16], key_item.key_byte, part_ff[7:0]};
                        default: part_in = {key_item.key_byte, part_ff[15:0]};
                     endcase
                     cnt_in = cnt_ff + 2'd1;
                  end
                  if (key_item.key_last) begin
                     state_in = H_FIN;
                  end
               end
            end
         end
         H_MIX1: begin
            mul_b    = MM_C1;
            acc_in   = prod;
            state_in = H_MIX2;
         end
         H_MIX2: begin
            mul_a    = {acc_ff[16:0], acc_ff[31:17]};
            mul_b    = MM_C2;
            acc_in   = prod;
            state_in = tail_ff ? H_FXOR : H_ROUND;
         end
         H_ROUND: begin
            hash_in  = {round_r[29:0], 2'b00} + round_r + MM_ROUND_N;
            state_in = last_ff ? H_FIN : H_IDLE;
         end
         H_FIN: begin
            if (cnt_ff != 2'd0) begin
               acc_in   = {8'h00, part_ff};
               tail_in  = 1'b1;
               state_in = H_MIX1;
            end else begin
               acc_in   = hash_ff ^ len_ff;
               state_in = H_FM1;
            end
         end
         H_FXOR: begin
            acc_in   = hash_ff ^ acc_ff ^ len_ff;
            state_in = H_FM1;
         end
         H_FM1: begin
            mul_a    = acc_ff ^ (acc_ff >> 16);
            mul_b    = MM_FMIX1;
            acc_in   = prod;
            state_in = H_FM2;
         end
         H_FM2: begin
            mul_a    = acc_ff ^ (acc_ff >> 13);
            mul_b    = MM_FMIX2;
            acc_in   = prod;
            state_in = H_FM3;
         end
         H_FM3: begin
            if (go_ok) begin
               stat.done = 1'b1;
               hash_in   = SEED_VALUE;
               len_in    = '0;
               part_in   = '0;
               cnt_in    = '0;
               state_in  = H_IDLE;
            end
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/chrr_search.sv
`timescale 1ns / 1ps
// Ring lookup: scans the ring RAM in index order for the first hash not below the key hash.
// Depends on chrr_pkg for widths, the ring entry type and the result struct.
module chrr_search
   import chrr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [HASH_W-1:0]     lookup_hash,
   input  logic [RING_CNT_W-1:0] ring_size,
   output logic [RING_IDX_W-1:0] rd_addr,
   input  ring_entry_type        rd_entry,
   output srch_res_type          res
);

   srch_state_type        state_ff, state_in;
   logic [HASH_W-1:0]     kh_ff, kh_in;
   logic [RING_CNT_W-1:0] size_ff, size_in;
   logic [RING_IDX_W-1:0] cur_ff, cur_in;
   logic [NODE_W-1:0]     first_ff, first_in;

   logic hit, at_end, at_first;

   assign hit      = (rd_entry.hash >= kh_ff);
   assign at_end   = ((RING_CNT_W'(cur_ff) + RING_CNT_W'(1)) == size_ff);
   assign at_first = (cur_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      kh_ff    <= kh_in;
      size_ff  <= size_in;
      cur_ff   <= cur_in;
      first_ff <= first_in;
   end

   always_comb begin
      state_in  = state_ff;
      kh_in     = kh_ff;
      size_in   = size_ff;
      cur_in    = cur_ff;
      first_in  = first_ff;
      rd_addr   = '0;
      res.busy  = 1'b0;
      res.valid = 1'b0;
      res.node  = '0;
      res.empty = 1'b0;
      unique case (state_ff)
         SR_IDLE: begin
            if (start) begin
               kh_in   = lookup_hash;
               size_in = ring_size;
               cur_in  = '0;
               if (ring_size == '0) begin
                  res.valid = 1'b1;
                  res.empty = 1'b1;
               end else begin
                  state_in = SR_SCAN;
               end
            end
         end
         SR_SCAN: begin
            res.busy = 1'b1;
            rd_addr  = cur_ff + RING_IDX_W'(1);
            if (at_first) begin
               first_in = rd_entry.node;
            end
            if (hit || at_end) begin
               res.valid = 1'b1;
               res.node  = (hit || at_first) ? rd_entry.node : first_ff;
               state_in  = SR_IDLE;
            end else begin
               cur_in = cur_ff + RING_IDX_W'(1);
            end
         end
         default: begin
            state_in = SR_IDLE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/consistent_hash_ring_router_core.sv
`timescale 1ns / 1ps
// Top level of the consistent-hash ring router: handshakes, ring RAM, result register.
// Depends on chrr_pkg, chrr_ram, chrr_hash and chrr_search.
//
// Usage: the request channel (req_valid, req_stall, req_data) carries two kinds of
// transfer. A load transfer writes one ring entry (point hash and node) at entry_index;
// entries go in ascending hash order. Key transfers stream the key bytes; the one with
// key_last set closes the key and later yields one transfer on the response channel
// (rsp_valid, rsp_stall, rsp_data) with the chosen node, or empty_error when the ring
// size is zero. The ring size is written on the csr port, which is always ready; the user
// must write it only while the block is idle, which the block itself does not enforce.
// Timing: a load transfer and a key byte that does not complete a four-byte block are taken
// without a stall; a byte that completes a block runs MIX1, MIX2 and ROUND, as the shared
// multiplier is used twice and the round is applied afterwards. Closing a key runs FIN, a
// tail mix if bytes are left, and FM1 to FM3; the ring scan then visits one entry per cycle,
// up to ring_size capped at RING_DEPTH, through the single RAM read port. req_stall stays
// high during all of that. The result sits in an output register, so a stalled receiver
// holds it while new transfers are taken, and the next key cannot finish until it drains.
// Reset is synchronous; it clears the key state, the ring size and the response valid.
// Ring RAM contents are not cleared.
module consistent_hash_ring_router_core
   import chrr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CFG_SIZE_W-1:0] csr_data
);

   logic [CFG_SIZE_W-1:0] ring_size_ff, ring_size_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_item_type          rsp_data_ff, rsp_data_in;

   hash_stat_type         hstat;
   srch_res_type          sres;
   logic [HASH_W-1:0]     lookup_hash;
   logic [RING_CNT_W-1:0] size_sat;
   logic [RING_IDX_W-1:0] rd_addr;
   logic [ENTRY_W-1:0]    rd_word;
   ring_entry_type        rd_entry;
   ring_entry_type        wr_entry;
   logic                  req_fire, load_fire, key_fire, wr_en, go_ok;

   assign req_stall = hstat.busy | sres.busy;
   assign req_fire  = req_valid & ~req_stall;
   assign load_fire = req_fire & (req_data.req_type == REQ_LOAD);
   assign key_fire  = req_fire & (req_data.req_type == REQ_KEY);
   assign wr_en     = load_fire & (32'(req_data.entry_index) < 32'(RING_DEPTH));
   assign go_ok     = ~rsp_valid_ff | ~rsp_stall;
   assign csr_ready = 1'b1;

   assign wr_entry.hash = req_data.entry_hash;
   assign wr_entry.node = NODE_W'(req_data.entry_node[NODE_STORE_W-1:0]);
   assign rd_entry      = rd_word;

   assign size_sat = (32'(ring_size_ff) > 32'(RING_DEPTH)) ? RING_CNT_W'(RING_DEPTH)
                                                            : RING_CNT_W'(ring_size_ff);

   chrr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (RING_DEPTH)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (RING_IDX_W'(req_data.entry_index)),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   chrr_hash u_hash (
      .clock       (clock),
      .reset       (reset),
      .key_fire    (key_fire),
      .key_item    (req_data),
      .go_ok       (go_ok),
      .stat        (hstat),
      .lookup_hash (lookup_hash)
   );

   chrr_search u_search (
      .clock       (clock),
      .reset       (reset),
      .start       (hstat.done),
      .lookup_hash (lookup_hash),
      .ring_size   (size_sat),
      .rd_addr     (rd_addr),
      .rd_entry    (rd_entry),
      .res         (sres)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_size_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ring_size_ff <= ring_size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      ring_size_in = (csr_valid && csr_ready) ? csr_data : ring_size_ff;
      rsp_valid_in = sres.valid | (rsp_valid_ff & rsp_stall);
      rsp_data_in  = rsp_data_ff;
      if (sres.valid) begin
         rsp_data_in.node_index  = 6'(sres.node);
         rsp_data_in.empty_error = sres.empty;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: verif/consistent_hash_ring_router_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for consistent_hash_ring_router_core: loads ring entries, streams keys,
// predicts each routed node with a MurmurHash3 and lower-bound model and compares every result.
// Depends on chrr_pkg and the router RTL only.
module consistent_hash_ring_router_core_test;
   import chrr_pkg::*;

   localparam logic [31:0] MUR_SEED   = 32'h0000_0001;
   localparam logic [31:0] MUR_K1     = 32'hcc9e_2d51;
   localparam logic [31:0] MUR_K2     = 32'h1b87_3593;
   localparam logic [31:0] MUR_ROUND  = 32'he654_6b64;
   localparam logic [31:0] MUR_AVAL1  = 32'h85eb_ca6b;
   localparam logic [31:0] MUR_AVAL2  = 32'hc2b2_ae35;
   localparam int          SETTLE_CYCLES = 16;
   localparam int          PHASE_ITEMS   = 45;
   localparam longint      TIMEOUT_NS    = 15_000_000;

   typedef struct packed {
      logic [31:0] acc;
      logic [31:0] len;
      logic [23:0] tail;
      logic [1:0]  tail_n;
   } murmur_state_type;

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_item_type    req_data;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_item_type    rsp_data;
   logic            csr_valid;
   logic            csr_ready;
   logic [8:0]      csr_data;

   logic [31:0]      ring_point_hash [RING_DEPTH];
   logic [5:0]       ring_point_node [RING_DEPTH];
   int               ring_span;
   int               loaded_prefix;
   murmur_state_type key_digest;
   rsp_item_type     pending_routes [$];
   int               error_count;
   bit               sender_idle_on;
   bit               receiver_idle_on;

   consistent_hash_ring_router_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
      return (x << r) | (x >> (32 - r));
   endfunction

   function automatic logic [31:0] scramble_block(input logic [31:0] k);
      logic [31:0] t;
      t = k * MUR_K1;
      t = rotl32(t, 15);
      return t * MUR_K2;
   endfunction

   function automatic murmur_state_type fresh_key_state();
      murmur_state_type s;
      s.acc    = MUR_SEED;
      s.len    = 32'd0;
      s.tail   = 24'd0;
      s.tail_n = 2'd0;
      return s;
   endfunction

   function automatic murmur_state_type absorb_key_byte(input murmur_state_type s,
                                                        input logic [7:0] b);
      murmur_state_type n;
      n     = s;
      n.len = s.len + 32'd1;
      if (s.tail_n == 2'd3) begin
         n.acc    = s.acc ^ scramble_block({b, s.tail});
         n.acc    = rotl32(n.acc, 13) * 32'd5 + MUR_ROUND;
         n.tail   = 24'd0;
         n.tail_n = 2'd0;
      end else begin
         n.tail   = s.tail | (24'(b) << (8 * int'(s.tail_n)));
         n.tail_n = s.tail_n + 2'd1;
      end
      return n;
   endfunction

   function automatic logic [31:0] finish_key_hash(input murmur_state_type s);
      logic [31:0] h;
      h = s.acc;
      if (s.tail_n != 2'd0) h = h ^ scramble_block({8'h00, s.tail});
      h = h ^ s.len;
      h = h ^ (h >> 16);
      h = h * MUR_AVAL1;
      h = h ^ (h >> 13);
      h = h * MUR_AVAL2;
      h = h ^ (h >> 16);
      return h;
   endfunction

   function automatic void predict_route(input req_item_type item);
      logic [31:0]  route_hash;
      rsp_item_type route;
      int           span;
      int           i;
      bit           found;
      if (item.req_type == REQ_LOAD) begin
         ring_point_hash[item.entry_index] = item.entry_hash;
         ring_point_node[item.entry_index] = item.entry_node;
         return;
      end
      if (item.byte_present) key_digest = absorb_key_byte(key_digest, item.key_byte);
      if (!item.key_last) return;
      route_hash = finish_key_hash(key_digest);
      key_digest = fresh_key_state();
      span = (ring_span > RING_DEPTH) ? RING_DEPTH : ring_span;
      route.node_index  = 6'd0;
      route.empty_error = 1'b0;
      if (span == 0) begin
         route.empty_error = 1'b1;
      end else begin
         route.node_index = ring_point_node[0];
         found = 1'b0;
         for (i = 0; i < span && !found; i++) begin
            if (ring_point_hash[i] >= route_hash) begin
               route.node_index = ring_point_node[i];
               found = 1'b1;
            end
         end
      end
      pending_routes = {pending_routes, route};
   endfunction

   function automatic req_item_type make_load(input logic [7:0] idx, input logic [31:0] h,
                                              input logic [5:0] node);
      req_item_type item;
      item.req_type     = REQ_LOAD;
      item.entry_index  = idx;
      item.entry_hash   = h;
      item.entry_node   = node;
      item.key_byte     = 8'($urandom);
      item.byte_present = 1'($urandom);
      item.key_last     = 1'($urandom);
      return item;
   endfunction

   function automatic req_item_type make_key(input logic [7:0] b, input logic present,
                                             input logic last);
      req_item_type item;
      item.req_type     = REQ_KEY;
      item.entry_index  = 8'($urandom);
      item.entry_hash   = $urandom;
      item.entry_node   = 6'($urandom);
      item.key_byte     = b;
      item.byte_present = present;
      item.key_last     = last;
      return item;
   endfunction

   task automatic send_request(input req_item_type item);
      int gap;
      gap = sender_idle_on ? int'($urandom_range(0, 15)) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_route(item);
   endtask

   task automatic drain_routes();
      req_valid <= 1'b0;
      while (pending_routes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_ring_size(input logic [8:0] size);
      drain_routes();
      csr_valid <= 1'b1;
      csr_data  <= size;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      ring_span = int'(size);
   endtask

   task automatic test_empty_ring();
      send_request(make_key(8'($urandom), 1'b0, 1'b1));
      send_request(make_key(8'h01, 1'b1, 1'b0));
      send_request(make_key(8'h80, 1'b1, 1'b0));
      send_request(make_key(8'($urandom), 1'b0, 1'b0));
      send_request(make_key(8'hfe, 1'b1, 1'b0));
      send_request(make_key(8'h7f, 1'b1, 1'b1));
   endtask

   task automatic test_ring_boundaries();
      logic [7:0]       probe_bytes [5];
      murmur_state_type probe;
      logic [31:0]      probe_hash;
      int               i;
      probe_bytes = '{8'ha5, 8'h5a, 8'hff, 8'h00, 8'h80};
      probe = fresh_key_state();
      for (i = 0; i < 5; i++) probe = absorb_key_byte(probe, probe_bytes[i]);
      probe_hash = finish_key_hash(probe);
      // The middle entry equals the probe key hash, so the probe hits the exact boundary.
      write_ring_size(9'd3);
      send_request(make_load(8'd0, 32'h0000_0000, 6'd63));
      send_request(make_load(8'd1, probe_hash, 6'd21));
      send_request(make_load(8'd2, 32'hffff_ffff, 6'd0));
      for (i = 0; i < 5; i++) send_request(make_key(probe_bytes[i], 1'b1, 1'(i == 4)));
      send_request(make_key(8'($urandom), 1'b0, 1'b1));
      send_request(make_key(8'hff, 1'b1, 1'b1));
      send_request(make_key(8'h00, 1'b1, 1'b0));
      send_request(make_key(8'h00, 1'b1, 1'b0));
      send_request(make_load(8'd2, 32'hffff_ffff, 6'd42));
      send_request(make_key(8'($urandom), 1'b0, 1'b0));
      send_request(make_key(8'h00, 1'b1, 1'b0));
      send_request(make_key(8'h00, 1'b1, 1'b0));
      send_request(make_key(8'($urandom), 1'b0, 1'b1));
   endtask

   task automatic test_random_routing();
      int          phase_sizes [12];
      int          p;
      int          n;
      int          i;
      int          sent;
      int          pick;
      bit          key_open;
      logic [63:0] step;
      phase_sizes = '{1, 2, 0, 7, 33, 256, 511, 3, 300, 16, 1, 64};
      key_open = 1'b0;
      for (p = 0; p < 12; p++) begin
         sender_idle_on   = (p % 3 != 0);
         receiver_idle_on = (p % 3 != 1);
         write_ring_size(9'(phase_sizes[p]));
         n = (phase_sizes[p] > RING_DEPTH) ? RING_DEPTH : phase_sizes[p];
         if (n > 0 && (n <= 40 || n > loaded_prefix)) begin
            step = 64'h1_0000_0000 / 64'(n);
            for (i = 0; i < n; i++)
               send_request(make_load(8'(i), 32'(64'(i) * step + 64'($urandom_range(0,
                                      32'(step - 64'd1)))), 6'($urandom)));
            if (n > loaded_prefix) loaded_prefix = n;
         end
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            pick = int'($urandom_range(0, 99));
            if (pick < 2) begin
               drain_routes();
            end else begin
               if (pick < 10) begin
                  send_request(make_load(8'($urandom), $urandom, 6'($urandom)));
               end else begin
                  send_request(make_key(8'($urandom), 1'($urandom_range(0, 9) != 0),
                                        1'($urandom_range(0, 5) == 0)));
                  key_open = !req_data.key_last;
               end
               sent++;
            end
         end
         if (key_open) begin
            send_request(make_key(8'($urandom), 1'($urandom), 1'b1));
            key_open = 1'b0;
         end
      end
   endtask

   initial begin
      int          rsp_hold_left;
      rsp_item_type expected;
      rsp_hold_left = 0;
      rsp_stall <= 1'b1;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_routes.size() == 0) begin
               $display("%0t: unexpected result node_index=%0d empty_error=%0b", $time,
                        rsp_data.node_index, rsp_data.empty_error);
               error_count++;
            end else begin
               expected = pending_routes.pop_front();
               if (rsp_data.node_index !== expected.node_index) begin
                  $display("%0t: node_index mismatch expected=%0d actual=%0d", $time,
                           expected.node_index, rsp_data.node_index);
                  error_count++;
               end
               if (rsp_data.empty_error !== expected.empty_error) begin
                  $display("%0t: empty_error mismatch expected=%0b actual=%0b", $time,
                           expected.empty_error, rsp_data.empty_error);
                  error_count++;
               end
            end
            rsp_hold_left = receiver_idle_on ? int'($urandom_range(0, 15)) : 0;
         end else if (rsp_valid === 1'b1 && rsp_hold_left > 0) begin
            rsp_hold_left--;
         end
         rsp_stall <= (rsp_hold_left != 0);
      end
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      error_count      = 0;
      ring_span        = 0;
      loaded_prefix    = 0;
      key_digest       = fresh_key_state();
      sender_idle_on   = 1'b1;
      receiver_idle_on = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_ring();
      test_ring_boundaries();
      test_random_routing();
      drain_routes();
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("%0t: timeout with %0d results outstanding", $time, pending_routes.size());
      $display("FAILURE");
      $finish;
   end

endmodule
